>>> hw/rtl/lgr_pkg.sv
// ----------------------------------------------------------------------------
// lgr_pkg: shared types and constants for the Life row generator
// Field widths, default board width and the result queue item.
// ----------------------------------------------------------------------------
package lgr_pkg;

  localparam int ROW_W         = 64;  // row_bits / next_row field width
  localparam int CFG_W         = 7;   // active_width register width
  localparam int BOARD_W_DEF   = 64;
  localparam int OUT_DEPTH_DEF = 4;   // result queue entries, power of two
  localparam logic [CFG_W-1:0] ACTIVE_W_RST = CFG_W'(64);

  // 3x3 neighborhood of one cell, bit 1 of each row is the cell's own column
  typedef struct packed {
    logic [2:0] up;
    logic [2:0] mid;
    logic [2:0] dn;
  } nbhd_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last;
  } item_t;

  // up to two results are queued per input transfer; first fills before second
  typedef struct packed {
    logic  first_vld;
    logic  second_vld;
    item_t first;
    item_t second;
  } push_t;

endpackage

>>> hw/rtl/lgr_lane.sv
// ----------------------------------------------------------------------------
// lgr_lane: one cell of the B3/S23 update
// Counts the eight neighbors and applies birth/survival.
// ----------------------------------------------------------------------------
module lgr_lane
  import lgr_pkg::*;
(
  input  nbhd_t nb,
  output logic  alive
);

  logic [3:0] n;

  always_comb begin
    n = 4'(nb.up[0]) + 4'(nb.up[1]) + 4'(nb.up[2]) +
        4'(nb.mid[0]) + 4'(nb.mid[2]) +
        4'(nb.dn[0]) + 4'(nb.dn[1]) + 4'(nb.dn[2]);
    if (nb.mid[1]) begin
      alive = (n == 4'd2) || (n == 4'd3);
    end else begin
      alive = (n == 4'd3);
    end
  end

endmodule

>>> hw/rtl/lgr_row.sv
// ----------------------------------------------------------------------------
// lgr_row: one full row update
// One lane per column working in parallel; lane bits are merged and masked
// to the active width.
// ----------------------------------------------------------------------------
module lgr_row
  import lgr_pkg::*;
#(
  parameter int BOARD_WIDTH = BOARD_W_DEF
) (
  input  logic [BOARD_WIDTH-1:0] up,
  input  logic [BOARD_WIDTH-1:0] mid,
  input  logic [BOARD_WIDTH-1:0] dn,
  input  logic [BOARD_WIDTH-1:0] mask,
  output logic [BOARD_WIDTH-1:0] res
);

  // dead border column on each side
  logic [BOARD_WIDTH+1:0] up_p, mid_p, dn_p;
  logic [BOARD_WIDTH-1:0] lane_alive;

  assign up_p  = {1'b0, up  & mask, 1'b0};
  assign mid_p = {1'b0, mid & mask, 1'b0};
  assign dn_p  = {1'b0, dn  & mask, 1'b0};

  for (genvar c = 0; c < BOARD_WIDTH; c++) begin : g_lane
    nbhd_t nb;
    assign nb.up  = up_p[c+2:c];
    assign nb.mid = mid_p[c+2:c];
    assign nb.dn  = dn_p[c+2:c];
    lgr_lane u_lane (
      .nb    (nb),
      .alive (lane_alive[c])
    );
  end

  assign res = lane_alive & mask;

endmodule

>>> hw/rtl/lgr_out_fifo.sv
// ----------------------------------------------------------------------------
// lgr_out_fifo: result queue
// Takes up to two items per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module lgr_out_fifo
  import lgr_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room2,
  output logic  out_vld,
  input  logic  out_rdy,
  output item_t out_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_vld  = (cnt_r != '0);
  assign out_item = mem[rd_ptr_r];
  assign pop      = out_vld && out_rdy;
  assign room2    = (cnt_r <= CNT_W'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.first_vld) + PTR_W'(push.second_vld);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push.first_vld) + CNT_W'(push.second_vld)
                 - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first_vld) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.second_vld) begin
      mem[PTR_W'(wr_ptr_r + PTR_W'(1))] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/life_generation_row_stream.sv
// Timing: a row's next generation enters the result queue in the cycle its lower
//   neighbor row is transferred and is offered on out_ behind earlier results.
// Throughput: one input row per cycle while the queue has room for two; the
//   bottom row of a taller board adds a second result; R rows take R transfers.
// Reset (rst_n low, synchronous): row buffers and queue emptied, active width 64.
// ----------------------------------------------------------------------------
// life_generation_row_stream: Conway Life (B3/S23) generation, row streamed
// Holds the two previous rows and computes each next-generation row with
// one lane per column; results pass through a small queue.
// ----------------------------------------------------------------------------
module life_generation_row_stream
  import lgr_pkg::*;
#(
  parameter int BOARD_WIDTH = BOARD_W_DEF,
  parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,     // active_width
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [ROW_W-1:0] in_tdata,     // [63:0] row_bits
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ROW_W-1:0] out_tdata,    // [63:0] next_row
  output logic             out_tlast
);

  logic [BOARD_WIDTH-1:0] mask_r, mask_nxt;
  logic [BOARD_WIDTH-1:0] above_r, above_nxt, middle_r, middle_nxt;
  logic [1:0]             held_r, held_nxt;
  logic [BOARD_WIDTH-1:0] row, above2, res_a, res_b;
  logic [CFG_W-1:0]       eff_w;
  logic                   in_xfer, have_rows, room2;
  push_t                  push;
  item_t                  out_item;

  assign cfg_ready = 1'b1;
  assign in_tready = room2;
  assign in_xfer   = in_tvalid && in_tready;
  assign have_rows = (held_r != 2'd0);

  // clamp width to 1..BOARD_WIDTH and expand to a column mask
  always_comb begin
    if (cfg_data == '0) begin
      eff_w = CFG_W'(1);
    end else if (cfg_data > CFG_W'(BOARD_WIDTH)) begin
      eff_w = CFG_W'(BOARD_WIDTH);
    end else begin
      eff_w = cfg_data;
    end
    for (int c = 0; c < BOARD_WIDTH; c++) begin
      mask_nxt[c] = (CFG_W'(c) < eff_w);
    end
  end

  assign row    = in_tdata[BOARD_WIDTH-1:0] & mask_r;
  // row above after this transfer, used for the bottom row's own result
  assign above2 = have_rows ? middle_r : '0;

  lgr_row #(.BOARD_WIDTH(BOARD_WIDTH)) u_row_a (
    .up   (above_r),
    .mid  (middle_r),
    .dn   (row),
    .mask (mask_r),
    .res  (res_a)
  );

  lgr_row #(.BOARD_WIDTH(BOARD_WIDTH)) u_row_b (
    .up   (above2),
    .mid  (row),
    .dn   ('0),
    .mask (mask_r),
    .res  (res_b)
  );

  always_comb begin
    push.first_vld   = in_xfer && (have_rows || in_tlast);
    push.second_vld  = in_xfer && have_rows && in_tlast;
    push.first.row   = have_rows ? ROW_W'(res_a) : ROW_W'(res_b);
    push.first.last  = !have_rows;
    push.second.row  = ROW_W'(res_b);
    push.second.last = 1'b1;

    above_nxt  = above_r;
    middle_nxt = middle_r;
    held_nxt   = held_r;
    if (in_xfer) begin
      if (in_tlast) begin
        above_nxt  = '0;
        middle_nxt = '0;
        held_nxt   = 2'd0;
      end else begin
        above_nxt  = above2;
        middle_nxt = row;
        held_nxt   = have_rows ? 2'd2 : 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '1;
      above_r  <= '0;
      middle_r <= '0;
      held_r   <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mask_r <= mask_nxt;
      end
      above_r  <= above_nxt;
      middle_r <= middle_nxt;
      held_r   <= held_nxt;
    end
  end

  lgr_out_fifo #(.DEPTH(OUT_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room2    (room2),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_item (out_item)
  );

  assign out_tdata = out_item.row;
  assign out_tlast = out_item.last;

endmodule

>>> hw/rtl/lgr_checker.sv
// ----------------------------------------------------------------------------
// lgr_checker: port-level checks for the Life row generator
// Attached to the top level by the bind below.
// ----------------------------------------------------------------------------
module lgr_checker
  import lgr_pkg::*;
#(
  parameter int BOARD_WIDTH = BOARD_W_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tlast,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [ROW_W-1:0] out_tdata,
  input logic             out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // bottom row always yields at least one result
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no result after bottom row transfer");

  // empty queue never stalls the input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result queue");

  // columns past the board are dead
  a_dead_cols: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata >> BOARD_WIDTH) == '0))
    else $error("live cell beyond board width");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind life_generation_row_stream lgr_checker #(.BOARD_WIDTH(BOARD_WIDTH)) u_lgr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
